// ===== hdl/bmpd_pkg.sv =====
// Shared types and constants for the 24-bit BMP stream decoder.
package bmpd_pkg;

  // One input byte of the file and its restart flag
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } bmpd_in_t;

  // One decoded result
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row_index;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [2:0]  error_code;
    logic        last_pixel;
  } bmpd_out_t;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_SIGNATURE   = 3'd0;
  localparam logic [2:0] ERR_VERSION     = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN_HDR = 3'd2;
  localparam logic [2:0] ERR_NOT_24BPP   = 3'd3;
  localparam logic [2:0] ERR_COMPRESSED  = 3'd4;
  localparam logic [2:0] ERR_BAD_SIZE    = 3'd5;
  localparam logic [2:0] ERR_BAD_OFFSET  = 3'd6;

  // Signature bytes
  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  // Header sizes
  localparam logic [31:0] HDR_LEN_INFO = 32'd40;
  localparam logic [31:0] HDR_LEN_CORE = 32'd12;
  localparam logic [31:0] HDR_LEN_V3   = 32'd64;
  localparam logic [31:0] HDR_LEN_V4   = 32'd108;
  localparam logic [31:0] HDR_LEN_V5   = 32'd124;

  // Bits per pixel accepted
  localparam logic [15:0] BPP_24 = 16'd24;

endpackage

// ===== hdl/bmp_24bit_stream_decoder_core.sv =====
// Top level of the 24-bit BMP stream decoder.
// Throughput: one file byte per cycle, sustained; a stalled result is held in a
//   two-entry output buffer, and input stalls only once both entries are full.
// Path: an input transfer is registered in the input stage, decoded by the
//   combinational parser, and then registered in the output head entry.
// Reset: synchronous on rst_n low; the parser returns to the signature check.
module bmp_24bit_stream_decoder_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmpd_pkg::bmpd_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bmpd_pkg::bmpd_out_t out_data
);
  import bmpd_pkg::*;

  logic      item_valid;
  bmpd_in_t  item_data;
  logic      item_take;
  logic      push_valid;
  logic      push_ready;
  bmpd_out_t push_data;

  // Input register
  bmpd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_take  (item_take)
  );

  // Header and pixel decode
  bmpd_parser #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_take  (item_take),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Result buffer
  bmpd_out_skid u_out_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== hdl/bmpd_in_reg.sv =====
// Input register stage: holds one accepted byte until the parser takes it.
module bmpd_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bmpd_pkg::bmpd_in_t in_data,
  output logic              item_valid,
  output bmpd_pkg::bmpd_in_t item_data,
  input  logic              item_take
);
  import bmpd_pkg::*;

  logic     valid_r;
  bmpd_in_t data_r;

  // Refill in the same cycle the parser drains the stage
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item_data  = data_r;

  // Hold or advance the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (item_take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== hdl/bmpd_parser.sv =====
// Header parser and pixel unpacker: one byte per transfer, at most one result.
module bmpd_parser #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  bmpd_pkg::bmpd_in_t  item_data,
  output logic               item_take,
  input  logic               push_ready,
  output logic               push_valid,
  output bmpd_pkg::bmpd_out_t push_data
);
  import bmpd_pkg::*;

  localparam int W_W   = $clog2(MAX_WIDTH + 1);
  localparam int H_W   = $clog2(MAX_HEIGHT + 1);
  localparam int RBC_W = $clog2(3 * MAX_WIDTH + 4);

  // Byte positions of the checked header fields
  localparam logic [31:0] POS_OFFSET_END = 32'd13;
  localparam logic [31:0] POS_HSIZE_END  = 32'd17;
  localparam logic [31:0] POS_I_WIDTH    = 32'd21;
  localparam logic [31:0] POS_I_HEIGHT   = 32'd25;
  localparam logic [31:0] POS_I_BPP      = 32'd29;
  localparam logic [31:0] POS_I_COMP     = 32'd33;
  localparam logic [31:0] POS_I_LAST     = 32'd53;
  localparam logic [31:0] POS_C_WIDTH    = 32'd19;
  localparam logic [31:0] POS_C_HEIGHT   = 32'd21;
  localparam logic [31:0] POS_C_LAST     = 32'd25;
  localparam logic [31:0] HDR_END_INFO   = 32'd54;
  localparam logic [31:0] HDR_END_CORE   = 32'd26;

  typedef enum logic [2:0] {
    PH_SIG,
    PH_HDR,
    PH_SKIP,
    PH_PIX,
    PH_HALT
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [31:0]        bp_r, bp_nxt;
  logic [31:0]        fs_r, fs_nxt;
  logic [31:0]        off_r, off_nxt;
  logic               hl40_r, hl40_nxt;
  logic               hl12_r, hl12_nxt;
  logic [W_W-1:0]     width_r, width_nxt;
  logic [H_W-1:0]     height_r, height_nxt;
  logic [W_W-1:0]     col_r, col_nxt;
  logic [H_W-1:0]     row_r, row_nxt;
  logic [RBC_W-1:0]   rbc_r, rbc_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic [7:0]         blue_r, blue_nxt;
  logic [7:0]         green_r, green_nxt;
  logic [RBC_W-1:0]   db_r, stride_r;
  logic [RBC_W-1:0]   db_w, db_pad;

  logic               res_valid;
  bmpd_out_t          res;

  // Row length in bytes and its padded stride, settled long before pixels
  assign db_w   = RBC_W'({width_r, 1'b0}) + RBC_W'(width_r);
  assign db_pad = db_w + RBC_W'(3);

  always_ff @(posedge clk) begin
    db_r     <= db_w;
    stride_r <= {db_pad[RBC_W-1:2], 2'b00};
  end

  assign item_take  = item_valid && push_ready;
  assign push_valid = item_take && res_valid;
  assign push_data  = res;

  // Decode one byte
  always_comb begin
    logic [7:0]       b;
    logic             first;
    phase_t           phase_c;
    logic [31:0]      bp_c;
    logic [31:0]      fs_c;
    logic [31:0]      off_c;
    logic             hl40_c;
    logic             hl12_c;
    logic [W_W-1:0]   width_c;
    logic [H_W-1:0]   height_c;
    logic [W_W-1:0]   col_c;
    logic [H_W-1:0]   row_c;
    logic [RBC_W-1:0] rbc_c;
    logic [1:0]       sub_c;
    logic [7:0]       blue_c;
    logic [7:0]       green_c;
    logic [31:0]      fs_n;
    logic [31:0]      bp_inc;
    logic [RBC_W-1:0] rbc_inc;
    logic             finish;
    logic             err_hit;
    logic [2:0]       err_code;
    logic             last;

    b     = item_data.data_byte;
    first = item_data.first_byte;

    // A restart flag clears all state before the byte is used
    phase_c  = first ? PH_SIG : phase_r;
    bp_c     = first ? '0 : bp_r;
    fs_c     = first ? '0 : fs_r;
    off_c    = first ? '0 : off_r;
    hl40_c   = first ? 1'b0 : hl40_r;
    hl12_c   = first ? 1'b0 : hl12_r;
    width_c  = first ? '0 : width_r;
    height_c = first ? '0 : height_r;
    col_c    = first ? '0 : col_r;
    row_c    = first ? '0 : row_r;
    rbc_c    = first ? '0 : rbc_r;
    sub_c    = first ? '0 : sub_r;
    blue_c   = first ? '0 : blue_r;
    green_c  = first ? '0 : green_r;

    phase_nxt  = phase_c;
    bp_nxt     = bp_c;
    fs_nxt     = fs_c;
    off_nxt    = off_c;
    hl40_nxt   = hl40_c;
    hl12_nxt   = hl12_c;
    width_nxt  = width_c;
    height_nxt = height_c;
    col_nxt    = col_c;
    row_nxt    = row_c;
    rbc_nxt    = rbc_c;
    sub_nxt    = sub_c;
    blue_nxt   = blue_c;
    green_nxt  = green_c;

    fs_n     = {b, fs_c[31:8]};
    bp_inc   = bp_c + 32'd1;
    rbc_inc  = rbc_c + RBC_W'(1);
    finish   = 1'b0;
    err_hit  = 1'b0;
    err_code = ERR_SIGNATURE;
    last     = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    case (phase_c)
      PH_SIG: begin
        if (bp_c == 32'd0) begin
          if (b != SIG_B) begin
            err_hit = 1'b1;
          end
        end else begin
          if (b != SIG_M) begin
            err_hit = 1'b1;
          end else begin
            phase_nxt = PH_HDR;
          end
        end
        err_code = ERR_SIGNATURE;
        bp_nxt   = bp_inc;
      end

      PH_HDR: begin
        fs_nxt = fs_n;
        bp_nxt = bp_inc;
        if (bp_c == POS_OFFSET_END) begin
          off_nxt = fs_n;
        end else if (bp_c == POS_HSIZE_END) begin
          if (fs_n == HDR_LEN_INFO) begin
            hl40_nxt = 1'b1;
          end else if (fs_n == HDR_LEN_CORE) begin
            hl12_nxt = 1'b1;
          end else if (fs_n == HDR_LEN_V3 || fs_n == HDR_LEN_V4 || fs_n == HDR_LEN_V5) begin
            err_hit  = 1'b1;
            err_code = ERR_VERSION;
          end else begin
            err_hit  = 1'b1;
            err_code = ERR_UNKNOWN_HDR;
          end
        end else if (hl40_c) begin
          if (bp_c == POS_I_WIDTH) begin
            if (fs_n[31] || fs_n == 32'd0 || fs_n > 32'(MAX_WIDTH)) begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_SIZE;
            end else begin
              width_nxt = W_W'(fs_n);
            end
          end else if (bp_c == POS_I_HEIGHT) begin
            if (fs_n[31] || fs_n == 32'd0 || fs_n > 32'(MAX_HEIGHT)) begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_SIZE;
            end else begin
              height_nxt = H_W'(fs_n);
            end
          end else if (bp_c == POS_I_BPP) begin
            if (fs_n[31:16] != BPP_24) begin
              err_hit  = 1'b1;
              err_code = ERR_NOT_24BPP;
            end
          end else if (bp_c == POS_I_COMP) begin
            if (fs_n != 32'd0) begin
              err_hit  = 1'b1;
              err_code = ERR_COMPRESSED;
            end
          end else if (bp_c == POS_I_LAST) begin
            finish = 1'b1;
          end
        end else if (hl12_c) begin
          if (bp_c == POS_C_WIDTH) begin
            if (fs_n[31:16] == 16'd0 || fs_n[31:16] > 16'(MAX_WIDTH)) begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_SIZE;
            end else begin
              width_nxt = W_W'(fs_n[31:16]);
            end
          end else if (bp_c == POS_C_HEIGHT) begin
            if (fs_n[31:16] == 16'd0 || fs_n[31:16] > 16'(MAX_HEIGHT)) begin
              err_hit  = 1'b1;
              err_code = ERR_BAD_SIZE;
            end else begin
              height_nxt = H_W'(fs_n[31:16]);
            end
          end else if (bp_c == POS_C_LAST) begin
            if (fs_n[31:16] != BPP_24) begin
              err_hit  = 1'b1;
              err_code = ERR_NOT_24BPP;
            end else begin
              finish = 1'b1;
            end
          end
        end

        // End of header: check the offset, report sizes
        if (finish) begin
          if (off_c < (hl40_c ? HDR_END_INFO : HDR_END_CORE)) begin
            err_hit  = 1'b1;
            err_code = ERR_BAD_OFFSET;
          end else begin
            res_valid          = 1'b1;
            res.kind           = KIND_HEADER;
            res.image_width    = 13'(width_c);
            res.image_height   = 13'(height_c);
            phase_nxt          = (off_c == bp_inc) ? PH_PIX : PH_SKIP;
          end
        end
      end

      PH_SKIP: begin
        bp_nxt = bp_inc;
        if (bp_inc == off_c) begin
          phase_nxt = PH_PIX;
        end
      end

      PH_PIX: begin
        // Gather B and G, emit on R; padding bytes only advance the count
        if (rbc_c < db_r) begin
          case (sub_c)
            2'd0: begin
              blue_nxt = b;
            end
            2'd1: begin
              green_nxt = b;
            end
            default: begin
              last = (W_W'(col_c + W_W'(1)) == width_c) &&
                     (H_W'(row_c + H_W'(1)) == height_c);
              res_valid      = 1'b1;
              res.kind       = KIND_PIXEL;
              res.red        = b;
              res.green      = green_c;
              res.blue       = blue_c;
              res.column     = 12'(col_c);
              res.row_index  = 12'(row_c);
              res.last_pixel = last;
              col_nxt        = W_W'(col_c + W_W'(1));
            end
          endcase
        end
        if (rbc_inc >= stride_r) begin
          rbc_nxt = '0;
          sub_nxt = '0;
          col_nxt = '0;
          row_nxt = H_W'(row_c + H_W'(1));
        end else begin
          rbc_nxt = rbc_inc;
          sub_nxt = (sub_c == 2'd2) ? 2'd0 : 2'(sub_c + 2'd1);
        end
        if (last) begin
          phase_nxt = PH_HALT;
        end
      end

      default: begin
      end
    endcase

    // Report an error and drop everything until a restart
    if (err_hit) begin
      res_valid      = 1'b1;
      res            = '0;
      res.kind       = KIND_ERROR;
      res.error_code = err_code;
      phase_nxt      = PH_HALT;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      bp_r     <= '0;
      fs_r     <= '0;
      off_r    <= '0;
      hl40_r   <= 1'b0;
      hl12_r   <= 1'b0;
      width_r  <= '0;
      height_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      rbc_r    <= '0;
      sub_r    <= '0;
      blue_r   <= '0;
      green_r  <= '0;
    end else if (item_take) begin
      phase_r  <= phase_nxt;
      bp_r     <= bp_nxt;
      fs_r     <= fs_nxt;
      off_r    <= off_nxt;
      hl40_r   <= hl40_nxt;
      hl12_r   <= hl12_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      rbc_r    <= rbc_nxt;
      sub_r    <= sub_nxt;
      blue_r   <= blue_nxt;
      green_r  <= green_nxt;
    end
  end

endmodule

// ===== hdl/bmpd_out_skid.sv =====
// Result register with a skid entry, so a single stalled result does not block input.
module bmpd_out_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  bmpd_pkg::bmpd_out_t push_data,
  output logic               push_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bmpd_pkg::bmpd_out_t out_data
);
  import bmpd_pkg::*;

  logic      head_v_r;
  logic      skid_v_r;
  bmpd_out_t head_r;
  bmpd_out_t skid_r;
  logic      pop;

  assign push_ready = !skid_v_r;
  assign out_valid  = head_v_r;
  assign out_data   = head_r;
  assign pop        = head_v_r && out_ready;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (pop) begin
      if (skid_v_r) begin
        skid_v_r <= push_valid;
      end else begin
        head_v_r <= push_valid;
      end
    end else if (push_valid) begin
      if (head_v_r) begin
        skid_v_r <= 1'b1;
      end else begin
        head_v_r <= 1'b1;
      end
    end
  end

  // Payload: advance the skid entry into the head on a transfer
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        head_r <= skid_r;
        if (push_valid) begin
          skid_r <= push_data;
        end
      end else if (push_valid) begin
        head_r <= push_data;
      end
    end else if (push_valid) begin
      if (head_v_r) begin
        skid_r <= push_data;
      end else begin
        head_r <= push_data;
      end
    end
  end

endmodule
